/* design/lfd_pkg.sv */
// shared types, constants and helper functions for the log field decoder
package lfd_pkg;

    localparam int VALUE_WIDTH_DEF      = 32;
    localparam int MAX_VARINT_BYTES_DEF = 5;
    localparam int OUT_W                = 33;
    localparam int MAX_RESULTS          = 4;
    localparam int CNT_W                = 3;

    // field encodings
    localparam logic [1:0] ENC_SVARINT = 2'd0;
    localparam logic [1:0] ENC_UVARINT = 2'd1;
    localparam logic [1:0] ENC_TAG2    = 2'd2;
    localparam logic [1:0] ENC_TAG8    = 2'd3;

    // tag2 lead selector codes
    localparam logic [1:0] LEAD_2BIT = 2'd0;
    localparam logic [1:0] LEAD_NIB  = 2'd1;
    localparam logic [1:0] LEAD_SIX  = 2'd2;
    localparam logic [1:0] LEAD_VAR  = 2'd3;

    // tag8 width codes
    localparam logic [1:0] T8_W0  = 2'd0;
    localparam logic [1:0] T8_W4  = 2'd1;
    localparam logic [1:0] T8_W8  = 2'd2;
    localparam logic [1:0] T8_W16 = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic [1:0]       value_index;
        logic             last;
        logic             overflow;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]          count;
    } batch_t;

    function automatic logic [1:0] sel_code(input logic [7:0] sel, input logic [1:0] g);
        logic [7:0] sh;
        sh = sel >> {g, 1'b0};
        return sh[1:0];
    endfunction

    function automatic logic [4:0] t8_width(input logic [1:0] code);
        logic [4:0] w;
        case (code)
            T8_W0:   w = 5'd0;
            T8_W4:   w = 5'd4;
            T8_W8:   w = 5'd8;
            T8_W16:  w = 5'd16;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

    function automatic logic [OUT_W-1:0] t8_sext(input logic [15:0] v, input logic [1:0] code);
        logic [OUT_W-1:0] r;
        case (code)
            T8_W4:   r = {{29{v[3]}}, v[3:0]};
            T8_W8:   r = {{25{v[7]}}, v[7:0]};
            T8_W16:  r = {{17{v[15]}}, v[15:0]};
            default: r = '0;
        endcase
        return r;
    endfunction

    // code 0..3 means 1..4 bytes
    function automatic logic [OUT_W-1:0] t2_sext(input logic [31:0] v, input logic [1:0] code);
        logic [OUT_W-1:0] r;
        case (code)
            2'd0:    r = {{25{v[7]}}, v[7:0]};
            2'd1:    r = {{17{v[15]}}, v[15:0]};
            2'd2:    r = {{9{v[23]}}, v[23:0]};
            default: r = {v[31], v};
        endcase
        return r;
    endfunction

    function automatic result_t make_result(input logic [OUT_W-1:0] v, input logic [1:0] idx,
                                            input logic lst, input logic ovf);
        result_t r;
        r.value       = v;
        r.value_index = idx;
        r.last        = lst;
        r.overflow    = ovf;
        return r;
    endfunction

endpackage

/* design/lfd_if.sv */
// request channels of the log field decoder: input bytes and decoded values
interface lfd_in_if import lfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       action;
    logic [1:0] encoding;
    logic [7:0] data_byte;

    modport source (output valid, output action, output encoding, output data_byte,
                    input ready);
    modport sink   (input valid, input action, input encoding, input data_byte,
                    output ready);
endinterface

interface lfd_out_if import lfd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] value;
    logic [1:0]              value_index;
    logic                    last;
    logic                    overflow;

    modport source (output valid, output value, output value_index, output last,
                    output overflow, input ready);
    modport sink   (input valid, input value, input value_index, input last,
                    input overflow, output ready);
endinterface

/* design/lfd_decoder.sv */
// field decode state and the single-step decode of one stream byte
module lfd_decoder import lfd_pkg::*; #(
    parameter int VALUE_WIDTH      = VALUE_WIDTH_DEF,
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       action,
    input  logic [1:0] encoding,
    input  logic [7:0] data_byte,
    output batch_t     batch,
    output logic       idle
);

    localparam int ACC_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int EXT_W = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;
    localparam int BC_W  = $clog2(MAX_VARINT_BYTES + 2);

    typedef enum logic [2:0] {
        PH_IDLE, PH_VARINT, PH_T2_NIB, PH_T2_SIX, PH_T2_VAR, PH_T8_DATA
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        enc_reg, enc_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [BC_W-1:0]   bc_reg, bc_next;
    logic [7:0]        sel_reg, sel_next;
    logic [1:0]        gi_reg, gi_next;
    logic [4:0]        bl_reg, bl_next;

    always_comb
    begin
        logic [2:0]               gi;
        logic [CNT_W-1:0]         n;
        result_t [MAX_RESULTS-1:0] res;
        logic                     do_var;
        logic                     do_skip;
        logic [3:0]               nib;
        logic [1:0]               code;
        logic [ACC_W+6:0]         grp;
        logic [VALUE_WIDTH-1:0]   u;
        logic [VALUE_WIDTH-1:0]   zz;
        logic [EXT_W-1:0]         ext;
        logic [31:0]              t2b;

        phase_next = phase_reg;
        enc_next   = enc_reg;
        acc_next   = acc_reg;
        bc_next    = bc_reg;
        sel_next   = sel_reg;
        bl_next    = bl_reg;
        gi         = {1'b0, gi_reg};
        n          = '0;
        res        = '0;
        do_var     = 1'b0;
        do_skip    = 1'b0;
        nib        = '0;
        code       = '0;
        grp        = '0;
        u          = '0;
        zz         = '0;
        ext        = '0;
        t2b        = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (action)
            begin
                res[n[1:0]] = make_result('0, 2'd0, 1'b1, 1'b0);
                n = n + 3'd1;
            end
            else
            begin
                enc_next = encoding;
                acc_next = '0;
                bc_next  = '0;
                gi       = '0;
                case (encoding)
                    ENC_SVARINT, ENC_UVARINT:
                    begin
                        phase_next = PH_VARINT;
                        do_var     = 1'b1;
                    end
                    ENC_TAG2:
                    begin
                        case (data_byte[7:6])
                            LEAD_2BIT:
                            begin
                                res[0] = make_result({{31{data_byte[5]}}, data_byte[5:4]},
                                                     2'd0, 1'b0, 1'b0);
                                res[1] = make_result({{31{data_byte[3]}}, data_byte[3:2]},
                                                     2'd1, 1'b0, 1'b0);
                                res[2] = make_result({{31{data_byte[1]}}, data_byte[1:0]},
                                                     2'd2, 1'b1, 1'b0);
                                n = 3'd3;
                                phase_next = PH_IDLE;
                            end
                            LEAD_NIB:
                            begin
                                res[0] = make_result({{29{data_byte[3]}}, data_byte[3:0]},
                                                     2'd0, 1'b0, 1'b0);
                                n = 3'd1;
                                phase_next = PH_T2_NIB;
                            end
                            LEAD_SIX:
                            begin
                                res[0] = make_result({{27{data_byte[5]}}, data_byte[5:0]},
                                                     2'd0, 1'b0, 1'b0);
                                n = 3'd1;
                                gi = 3'd1;
                                phase_next = PH_T2_SIX;
                            end
                            default:
                            begin
                                sel_next   = data_byte;
                                phase_next = PH_T2_VAR;
                            end
                        endcase
                    end
                    default:
                    begin
                        sel_next = data_byte;
                        do_skip  = 1'b1;
                    end
                endcase
            end
        end
        else if (!action)
        begin
            case (phase_reg)
                PH_VARINT:
                    do_var = 1'b1;
                PH_T2_NIB:
                begin
                    res[0] = make_result({{29{data_byte[7]}}, data_byte[7:4]},
                                         2'd1, 1'b0, 1'b0);
                    res[1] = make_result({{29{data_byte[3]}}, data_byte[3:0]},
                                         2'd2, 1'b1, 1'b0);
                    n = 3'd2;
                    phase_next = PH_IDLE;
                end
                PH_T2_SIX:
                begin
                    res[0] = make_result({{27{data_byte[5]}}, data_byte[5:0]},
                                         gi[1:0], gi >= 3'd2, 1'b0);
                    n = 3'd1;
                    gi = gi + 3'd1;
                    if (gi >= 3'd3)
                        phase_next = PH_IDLE;
                end
                PH_T2_VAR:
                begin
                    code = sel_code(sel_next, gi[1:0]);
                    t2b  = 32'(data_byte) << {bc_next[1:0], 3'b000};
                    acc_next[31:0] = acc_next[31:0] | t2b;
                    bc_next = bc_next + BC_W'(1);
                    if (int'(bc_next) >= int'(code) + 1)
                    begin
                        res[0] = make_result(t2_sext(acc_next[31:0], code),
                                             gi[1:0], gi >= 3'd2, 1'b0);
                        n = 3'd1;
                        gi = gi + 3'd1;
                        acc_next = '0;
                        bc_next  = '0;
                        if (gi >= 3'd3)
                            phase_next = PH_IDLE;
                    end
                end
                PH_T8_DATA:
                begin
                    // high nibble first, then low nibble
                    for (int k = 0; k < 2; k++)
                    begin
                        nib = (k == 0) ? data_byte[7:4] : data_byte[3:0];
                        if (phase_next == PH_T8_DATA)
                        begin
                            acc_next = ACC_W'({acc_next[11:0], nib});
                            bl_next  = (bl_next >= 5'd4) ? bl_next - 5'd4 : 5'd0;
                            if (bl_next == 5'd0)
                            begin
                                code = sel_code(sel_next, gi[1:0]);
                                res[n[1:0]] = make_result(t8_sext(acc_next[15:0], code),
                                                          gi[1:0], gi >= 3'd3, 1'b0);
                                n  = n + 3'd1;
                                gi = gi + 3'd1;
                                // zero-width values follow at once
                                for (int j = 0; j < MAX_RESULTS; j++)
                                begin
                                    if (!gi[2] && sel_code(sel_next, gi[1:0]) == T8_W0)
                                    begin
                                        res[n[1:0]] = make_result('0, gi[1:0],
                                                                  gi == 3'd3, 1'b0);
                                        n  = n + 3'd1;
                                        gi = gi + 3'd1;
                                    end
                                end
                                if (gi[2])
                                    phase_next = PH_IDLE;
                                else
                                begin
                                    bl_next  = t8_width(sel_code(sel_next, gi[1:0]));
                                    acc_next = '0;
                                end
                            end
                        end
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        if (do_var)
        begin
            if (int'(bc_next) < MAX_VARINT_BYTES && 7 * int'(bc_next) < VALUE_WIDTH)
            begin
                grp = (ACC_W + 7)'(data_byte[6:0]) << (7 * int'(bc_next));
                acc_next[VALUE_WIDTH-1:0] = acc_next[VALUE_WIDTH-1:0] | grp[VALUE_WIDTH-1:0];
            end
            if (int'(bc_next) <= MAX_VARINT_BYTES)
                bc_next = bc_next + BC_W'(1);
            if (!data_byte[7])
            begin
                u  = acc_next[VALUE_WIDTH-1:0];
                zz = (u >> 1) ^ {VALUE_WIDTH{u[0]}};
                if (enc_next == ENC_SVARINT)
                    ext = EXT_W'(signed'(zz));
                else
                    ext = EXT_W'(u);
                res[0] = make_result(ext[OUT_W-1:0], 2'd0, 1'b1,
                                     int'(bc_next) > MAX_VARINT_BYTES);
                n = 3'd1;
                phase_next = PH_IDLE;
            end
        end

        if (do_skip)
        begin
            for (int j = 0; j < MAX_RESULTS; j++)
            begin
                if (!gi[2] && sel_code(sel_next, gi[1:0]) == T8_W0)
                begin
                    res[n[1:0]] = make_result('0, gi[1:0], gi == 3'd3, 1'b0);
                    n  = n + 3'd1;
                    gi = gi + 3'd1;
                end
            end
            if (gi[2])
                phase_next = PH_IDLE;
            else
            begin
                bl_next    = t8_width(sel_code(sel_next, gi[1:0]));
                acc_next   = '0;
                phase_next = PH_T8_DATA;
            end
        end

        gi_next     = gi[1:0];
        batch.res   = res;
        batch.count = n;
    end

    assign idle = (phase_reg == PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            enc_reg   <= '0;
            acc_reg   <= '0;
            bc_reg    <= '0;
            sel_reg   <= '0;
            gi_reg    <= '0;
            bl_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            enc_reg   <= enc_next;
            acc_reg   <= acc_next;
            bc_reg    <= bc_next;
            sel_reg   <= sel_next;
            gi_reg    <= gi_next;
            bl_reg    <= bl_next;
        end
    end

endmodule

/* design/lfd_result_queue.sv */
// result register bank that hands out the values of one byte in order
module lfd_result_queue import lfd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  batch_t     batch,
    output logic       free,
    lfd_out_if.source  outbound
);

    result_t [MAX_RESULTS-1:0] entries_reg;
    logic [CNT_W-1:0]          remain_reg;
    logic [1:0]                ptr_reg;
    logic                      take;
    result_t                   head;

    assign head               = entries_reg[ptr_reg];
    assign outbound.valid       = (remain_reg != '0);
    assign outbound.value       = head.value;
    assign outbound.value_index = head.value_index;
    assign outbound.last        = head.last;
    assign outbound.overflow    = head.overflow;

    assign take = outbound.valid && outbound.ready;
    assign free = (remain_reg == '0) || (remain_reg == CNT_W'(1) && take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            ptr_reg    <= '0;
        end
        else if (load)
        begin
            remain_reg <= batch.count;
            ptr_reg    <= '0;
        end
        else if (take)
        begin
            remain_reg <= remain_reg - CNT_W'(1);
            ptr_reg    <= ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            entries_reg <= batch.res;
    end

endmodule

/* design/log_field_decoder_core.sv */
// top level of the log field decoder: input register, decode step, result bank
// Decodes a log byte stream one field at a time. Each request carries one byte
// (or a null action); the field encoding is sampled on the first byte of a field
// and held until the field ends: signed (zigzag) varint, unsigned varint,
// tag2_3s32 or tag8_4s16. Each decoded value leaves as one output request with
// its position in the field group, a last flag, and an overflow flag for varints
// longer than MAX_VARINT_BYTES. A byte is taken into an input register, decoded
// in a single pass against the field state, and its results (zero to four) are
// loaded into a result register bank that hands them out one per cycle while
// the output is ready. Bytes flow at one per cycle while each yields at most one
// value and the output is ready; a byte with more values holds the next byte
// until the single output port of the bank hands out its last one. A byte waits
// in the input register while the bank is busy. A null action at field start
// yields one zero value; a null inside a field is consumed without a value.
module log_field_decoder_core import lfd_pkg::*; #(
    parameter int VALUE_WIDTH      = VALUE_WIDTH_DEF,
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lfd_in_if.sink    inbound,
    lfd_out_if.source outbound
);

    // input register
    logic       in_valid_reg;
    logic       action_reg;
    logic [1:0] encoding_reg;
    logic [7:0] data_byte_reg;

    logic   step_fire;
    logic   buf_free;
    logic   dec_idle;
    batch_t batch;

    // a held byte is decoded once the result bank can take all its values
    assign step_fire     = in_valid_reg && buf_free;
    assign inbound.ready = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (inbound.ready)
            in_valid_reg <= inbound.valid;
    end

    always_ff @(posedge clk)
    begin
        if (inbound.valid && inbound.ready)
        begin
            action_reg    <= inbound.action;
            encoding_reg  <= inbound.encoding;
            data_byte_reg <= inbound.data_byte;
        end
    end

    // field state and the decode of one byte
    lfd_decoder #(
        .VALUE_WIDTH      (VALUE_WIDTH),
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (step_fire),
        .action    (action_reg),
        .encoding  (encoding_reg),
        .data_byte (data_byte_reg),
        .batch     (batch),
        .idle      (dec_idle)
    );

    // values of one byte, handed out in order
    lfd_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step_fire),
        .batch    (batch),
        .free     (buf_free),
        .outbound (outbound)
    );

    // overflow only ever marks the single value of a varint field
    a_overflow_single: assert property (@(posedge clk) disable iff (!rst_n)
        outbound.valid && outbound.overflow |-> outbound.last && outbound.value_index == 2'd0)
        else $error("overflow on a value that is not a varint result");

    // the input side only stalls on a held byte that the result bank cannot take
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !inbound.ready |-> in_valid_reg && !buf_free)
        else $error("input stalled without a pending byte");

    // a null request at field start yields exactly one value
    a_null_start: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && dec_idle && action_reg |-> batch.count == CNT_W'(1))
        else $error("null at field start did not yield one value");

endmodule
